[sv/rrbm_pkg.sv]
// shared types, codes and helpers for the rom/ram bank mapper
`default_nettype none

package rrbm_pkg;

    localparam int ROM_BANK_W = 7;
    localparam int RAM_BANK_W = 2;
    localparam int ROM_ADDR_W = 21;
    localparam int RAM_ADDR_W = 15;
    localparam int BUS_ADDR_W = 16;
    localparam int DATA_W     = 8;

    // access kind
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // top three address bits of the external ram window
    localparam logic [2:0] RAM_WINDOW = 3'b101;
    // low nibble that switches ram on
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_ROM  = 2'd1,
        TGT_RAM  = 2'd2
    } t_target;

    // register selected by address bits 14:13 on a write below 0x8000
    typedef enum logic [1:0] {
        SEL_RAM_EN = 2'd0,
        SEL_ROM_LO = 2'd1,
        SEL_ROM_HI = 2'd2,
        SEL_MODE   = 2'd3
    } t_reg_sel;

    typedef struct packed {
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  ram_en;
        logic                  ram_mode;
    } t_bank_state;

    typedef struct packed {
        t_target               target;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic [RAM_ADDR_W-1:0] ram_address;
        logic                  ram_write;
        logic [DATA_W-1:0]     ram_write_data;
    } t_result;

    // banks 0x00, 0x20, 0x40, 0x60 step up to the next bank
    function automatic logic [ROM_BANK_W-1:0] fix_rom_bank(input logic [ROM_BANK_W-1:0] bank);
        logic [ROM_BANK_W-1:0] fixed;
        fixed = bank;
        if (bank[4:0] == 5'd0) begin
            fixed[0] = 1'b1;
        end
        return fixed;
    endfunction

endpackage

`default_nettype wire

[sv/rrbm_in_if.sv]
// bus access channel: one beat is one cpu read or write
`default_nettype none

interface rrbm_in_if
    import rrbm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [BUS_ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0]     write_byte;

    modport source (output valid, command, bus_address, write_byte, input ready);
    modport sink   (input valid, command, bus_address, write_byte, output ready);
endinterface

`default_nettype wire

[sv/rrbm_out_if.sv]
// mapped access channel: one beat is one decoded memory access
`default_nettype none

interface rrbm_out_if
    import rrbm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [1:0]            target;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [RAM_ADDR_W-1:0] ram_address;
    logic                  ram_write;
    logic [DATA_W-1:0]     ram_write_data;

    modport source (output valid, target, rom_address, ram_address, ram_write,
                    ram_write_data, input ready);
    modport sink   (input valid, target, rom_address, ram_address, ram_write,
                    ram_write_data, output ready);
endinterface

`default_nettype wire

[sv/rrbm_decode.sv]
// address decode and bank register update for one bus access
`default_nettype none

module rrbm_decode
    import rrbm_pkg::*;
(
    input  wire logic                  i_command,
    input  wire logic [BUS_ADDR_W-1:0] i_bus_address,
    input  wire logic [DATA_W-1:0]     i_write_byte,
    input  wire t_bank_state           i_state,
    input  wire logic                  i_ram_present,
    output t_bank_state                o_next_state,
    output t_result                    o_result
);

    t_reg_sel sel;

    assign sel = t_reg_sel'(i_bus_address[14:13]);

    always_comb begin
        o_next_state = i_state;
        o_result     = '0;
        o_result.target = TGT_NONE;
        if (!i_bus_address[15]) begin
            if (i_command == CMD_READ) begin
                o_result.target = TGT_ROM;
                if (i_bus_address[14]) begin
                    o_result.rom_address = {i_state.rom_bank, i_bus_address[13:0]};
                end else begin
                    o_result.rom_address = {{ROM_BANK_W{1'b0}}, i_bus_address[13:0]};
                end
            end else begin
                case (sel)
                    SEL_RAM_EN: begin
                        o_next_state.ram_en = (i_write_byte[3:0] == RAM_ENABLE_KEY);
                    end
                    SEL_ROM_LO: begin
                        o_next_state.rom_bank =
                            fix_rom_bank({i_state.rom_bank[6:5], i_write_byte[4:0]});
                    end
                    SEL_ROM_HI: begin
                        if (i_state.ram_mode) begin
                            o_next_state.ram_bank = i_write_byte[1:0];
                            o_next_state.rom_bank =
                                fix_rom_bank({2'b00, i_state.rom_bank[4:0]});
                        end else begin
                            o_next_state.ram_bank = '0;
                            o_next_state.rom_bank =
                                fix_rom_bank({i_write_byte[1:0], i_state.rom_bank[4:0]});
                        end
                    end
                    SEL_MODE: begin
                        o_next_state.ram_mode = i_write_byte[0];
                    end
                    default: begin
                        o_next_state = i_state;
                    end
                endcase
            end
        end else if (i_bus_address[15:13] == RAM_WINDOW) begin
            if (i_ram_present && i_state.ram_en) begin
                o_result.target      = TGT_RAM;
                o_result.ram_address = {i_state.ram_bank, i_bus_address[12:0]};
                if (i_command == CMD_WRITE) begin
                    o_result.ram_write      = 1'b1;
                    o_result.ram_write_data = i_write_byte;
                end
            end
        end
    end

endmodule

`default_nettype wire

[sv/rrbm_bank_regs.sv]
// bank controller registers and the ram-present setting
`default_nettype none

module rrbm_bank_regs
    import rrbm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_update,
    input  wire t_bank_state i_next_state,
    input  wire logic  i_cfg_wr_en,
    input  wire logic  i_cfg_wr_data,
    output t_bank_state o_state,
    output logic       o_ram_present
);

    t_bank_state r_state;
    logic        r_ram_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.rom_bank <= ROM_BANK_W'(1);
            r_state.ram_bank <= '0;
            r_state.ram_en   <= 1'b0;
            r_state.ram_mode <= 1'b0;
        end else if (i_update) begin
            r_state <= i_next_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_present <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_ram_present <= i_cfg_wr_data;
        end
    end

    assign o_state       = r_state;
    assign o_ram_present = r_ram_present;

endmodule

`default_nettype wire

[sv/rom_ram_bank_mapper_top.sv]
// top level of the rom/ram bank mapper: input register, decode, result register
// The mapper turns each cpu bus beat into an external rom or ram access in the
// style of a classic cartridge bank controller. Writes below 0x8000 never reach
// memory: they set ram enable, the rom bank (low five and high two bits), the ram
// bank and the banking mode, and produce a beat with target none. Reads below
// 0x4000 hit rom bank 0, reads in 0x4000-0x7fff hit the current rom bank, and
// accesses in 0xa000-0xbfff hit ram only when ram is fitted (cfg bit) and
// enabled; otherwise target is none and a read sees open bus. Every input beat
// yields exactly one output beat, in order. A beat goes from the input register
// to the result register, with the decode and the bank register update done in
// one pass of logic between them. Both stages advance independently, so one beat
// is taken every cycle while the output side keeps up; back-pressure from the
// output stalls the result register first and the input register next. Bank
// registers change as a beat moves into the result register, so later beats
// always see the effect of earlier writes. The user must write the ram-present
// bit through the cfg port while no beat is inside; the block does not check.
`default_nettype none

module rom_ram_bank_mapper_top
    import rrbm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_wr_en,
    input  wire logic i_cfg_wr_data,
    rrbm_in_if.sink   i_req,
    rrbm_out_if.source o_rsp
);

    // input register stage
    logic                  r_in_valid;
    logic                  r_in_command;
    logic [BUS_ADDR_W-1:0] r_in_address;
    logic [DATA_W-1:0]     r_in_byte;

    // result register stage
    logic    r_out_valid;
    t_result r_out;

    t_bank_state bank_state;
    t_bank_state next_state;
    t_result     dec_result;
    logic        ram_present;
    logic        advance;   // beat moves from input register to result register
    logic        in_take;   // beat accepted from the bus side

    assign advance = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign in_take = i_req.valid && i_req.ready;

    // input register frees up when its beat moves on
    assign i_req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_command <= i_req.command;
            r_in_address <= i_req.bus_address;
            r_in_byte    <= i_req.write_byte;
        end
    end

    rrbm_decode u_decode (
        .i_command     (r_in_command),
        .i_bus_address (r_in_address),
        .i_write_byte  (r_in_byte),
        .i_state       (bank_state),
        .i_ram_present (ram_present),
        .o_next_state  (next_state),
        .o_result      (dec_result)
    );

    // bank registers commit together with the beat's result
    rrbm_bank_regs u_bank_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_update      (advance),
        .i_next_state  (next_state),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_state       (bank_state),
        .o_ram_present (ram_present)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= dec_result;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.target         = r_out.target;
    assign o_rsp.rom_address    = r_out.rom_address;
    assign o_rsp.ram_address    = r_out.ram_address;
    assign o_rsp.ram_write      = r_out.ram_write;
    assign o_rsp.ram_write_data = r_out.ram_write_data;

    // a ram write beat must carry a ram target
    a_write_is_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.ram_write |-> o_rsp.target == TGT_RAM)
        else $error("ram write without ram target");

    // rom address stays clear unless the beat goes to rom
    a_rom_addr_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.target != TGT_ROM |-> o_rsp.rom_address == '0)
        else $error("stray rom address");

    // the low five rom bank bits never select bank zero of a group
    a_bank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> bank_state.rom_bank[4:0] != 5'd0)
        else $error("rom bank low bits are zero");

    // bank registers only move when a beat advances
    a_bank_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(advance) |-> $stable(bank_state))
        else $error("bank registers changed without a beat");

endmodule

`default_nettype wire

[bench/testbench.sv]
// self-checking bench for the rom/ram bank mapper: directed rows, then random bus traffic
`default_nettype none

module testbench;
    import rrbm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // random traffic: four phases, with the ram-present bit set anew before each
    localparam int PHASES           = 4;
    localparam int BEATS_PER_PHASE  = 330;
    // one long output hold-off once this many beats have gone in
    localparam int LONG_HOLD_AT     = 700;
    localparam int LONG_HOLD_CYCLES = 80;
    // mismatch lines printed before going quiet (all are still counted)
    localparam int MAX_REPORTS      = 40;

    typedef enum logic {
        ROW_ACCESS = 1'b0,
        ROW_CFG    = 1'b1
    } t_row_kind;

    // one directed row: a bus beat or a ram-present write (value in data bit 0)
    typedef struct packed {
        t_row_kind          kind;
        logic               command;
        logic [15:0]        bus_address;
        logic [DATA_W-1:0]  write_byte;
        logic               typed;
        t_result            want;
    } t_dir_row;

    localparam t_result NO_HIT = '{TGT_NONE, 21'h0, 15'h0, 1'b0, 8'h00};

    // rows with typed set carry the obvious result; the rest go through the predictor
    localparam t_dir_row DIRECTED_ROWS [29] = '{
        // after reset: bank 0 window, bank 1 window, both ends of each
        '{ROW_ACCESS, CMD_READ,  16'h0000, 8'h00, 1'b1, '{TGT_ROM, 21'h000000, 15'h0, 1'b0, 8'h00}},
        '{ROW_ACCESS, CMD_READ,  16'h3FFF, 8'hA5, 1'b1, '{TGT_ROM, 21'h003FFF, 15'h0, 1'b0, 8'h00}},
        '{ROW_ACCESS, CMD_READ,  16'h4000, 8'h00, 1'b1, '{TGT_ROM, 21'h004000, 15'h0, 1'b0, 8'h00}},
        '{ROW_ACCESS, CMD_READ,  16'h7FFF, 8'h00, 1'b1, '{TGT_ROM, 21'h007FFF, 15'h0, 1'b0, 8'h00}},
        // unmapped regions
        '{ROW_ACCESS, CMD_READ,  16'h8000, 8'h00, 1'b1, NO_HIT},
        '{ROW_ACCESS, CMD_READ,  16'hFFFF, 8'hFF, 1'b1, NO_HIT},
        // ram window with ram absent and disabled
        '{ROW_ACCESS, CMD_READ,  16'hA000, 8'h00, 1'b1, NO_HIT},
        '{ROW_ACCESS, CMD_WRITE, 16'hA000, 8'h55, 1'b1, NO_HIT},
        // enable ram, but it is still absent
        '{ROW_ACCESS, CMD_WRITE, 16'h0000, 8'h0A, 1'b1, NO_HIT},
        '{ROW_ACCESS, CMD_READ,  16'hBFFF, 8'h00, 1'b1, NO_HIT},
        '{ROW_CFG,    CMD_READ,  16'h0000, 8'h01, 1'b0, NO_HIT},
        // ram fitted and enabled: both ends of the window, read and write
        '{ROW_ACCESS, CMD_READ,  16'hA000, 8'h00, 1'b1, '{TGT_RAM, 21'h0, 15'h0000, 1'b0, 8'h00}},
        '{ROW_ACCESS, CMD_WRITE, 16'hBFFF, 8'hFF, 1'b1, '{TGT_RAM, 21'h0, 15'h1FFF, 1'b1, 8'hFF}},
        // low bank bits zero: bank 0 steps up to 1
        '{ROW_ACCESS, CMD_WRITE, 16'h2000, 8'h00, 1'b1, NO_HIT},
        '{ROW_ACCESS, CMD_READ,  16'h4000, 8'h00, 1'b0, NO_HIT},
        // top rom bank 0x7f, last rom byte
        '{ROW_ACCESS, CMD_WRITE, 16'h3FFF, 8'h1F, 1'b1, NO_HIT},
        '{ROW_ACCESS, CMD_WRITE, 16'h4000, 8'h03, 1'b1, NO_HIT},
        '{ROW_ACCESS, CMD_READ,  16'h7FFF, 8'h00, 1'b1, '{TGT_ROM, 21'h1FFFFF, 15'h0, 1'b0, 8'h00}},
        // bank 0x60 is replaced by 0x61
        '{ROW_ACCESS, CMD_WRITE, 16'h2000, 8'hE0, 1'b1, NO_HIT},
        '{ROW_ACCESS, CMD_READ,  16'h4000, 8'h00, 1'b0, NO_HIT},
        // ram banking mode: upper write selects the ram bank and clears rom bits 5-6
        '{ROW_ACCESS, CMD_WRITE, 16'h6000, 8'h01, 1'b1, NO_HIT},
        '{ROW_ACCESS, CMD_WRITE, 16'h5FFF, 8'h03, 1'b1, NO_HIT},
        '{ROW_ACCESS, CMD_READ,  16'hA123, 8'h00, 1'b0, NO_HIT},
        '{ROW_ACCESS, CMD_WRITE, 16'hB456, 8'h3C, 1'b0, NO_HIT},
        // wrong key disables ram again
        '{ROW_ACCESS, CMD_WRITE, 16'h1FFF, 8'h1B, 1'b1, NO_HIT},
        '{ROW_ACCESS, CMD_READ,  16'hA000, 8'h00, 1'b1, NO_HIT},
        // back to rom banking mode, then a write to the top unmapped region
        '{ROW_ACCESS, CMD_WRITE, 16'h7FFF, 8'hFE, 1'b1, NO_HIT},
        '{ROW_ACCESS, CMD_WRITE, 16'hC000, 8'hAA, 1'b1, NO_HIT},
        '{ROW_CFG,    CMD_READ,  16'h0000, 8'h00, 1'b0, NO_HIT}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    rrbm_in_if  req_if ();
    rrbm_out_if rsp_if ();

    rom_ram_bank_mapper_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_if),
        .o_rsp         (rsp_if)
    );

    // bench copy of the bank controller state and the ram-present bit
    logic [ROM_BANK_W-1:0] cur_rom_bank;
    logic [RAM_BANK_W-1:0] cur_ram_bank;
    logic                  cur_ram_en;
    logic                  cur_ram_mode;
    logic                  cur_ram_present;

    // mapped accesses still to come out of the block, oldest first
    t_result pending_accesses [$];

    int unsigned beats_sent;
    int unsigned results_seen;
    int unsigned error_count;
    int unsigned cfg_writes;
    int unsigned longest_input_stall;
    int unsigned rom_hits;
    int unsigned ram_reads;
    int unsigned ram_writes;
    int unsigned no_hits;
    bit          long_hold_done;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // banks 0x00, 0x20, 0x40 and 0x60 are never selectable
    function automatic logic [ROM_BANK_W-1:0] skip_zero_bank(input logic [ROM_BANK_W-1:0] b);
        return (b[4:0] == 5'd0) ? b + 1'b1 : b;
    endfunction

    // decode one bus beat and apply any register write it carries
    function automatic t_result map_access(input logic cmd, input logic [15:0] addr,
                                           input logic [DATA_W-1:0] data);
        t_result r;
        r = NO_HIT;
        if (!addr[15]) begin
            if (cmd == CMD_READ) begin
                r.target = TGT_ROM;
                // bank 0 window is the raw address, upper window goes through the bank
                if (!addr[14]) begin
                    r.rom_address = {5'd0, addr};
                end else begin
                    r.rom_address = {cur_rom_bank, addr[13:0]};
                end
            end else begin
                case (t_reg_sel'(addr[14:13]))
                    SEL_RAM_EN: begin
                        cur_ram_en = (data[3:0] == RAM_ENABLE_KEY);
                    end
                    SEL_ROM_LO: begin
                        cur_rom_bank = skip_zero_bank({cur_rom_bank[6:5], data[4:0]});
                    end
                    SEL_ROM_HI: begin
                        if (cur_ram_mode) begin
                            cur_ram_bank = data[1:0];
                            cur_rom_bank = skip_zero_bank({2'b00, cur_rom_bank[4:0]});
                        end else begin
                            cur_rom_bank = skip_zero_bank({data[1:0], cur_rom_bank[4:0]});
                            cur_ram_bank = '0;
                        end
                    end
                    default: begin
                        cur_ram_mode = data[0];
                    end
                endcase
            end
        end else if (addr[15:13] == RAM_WINDOW && cur_ram_present && cur_ram_en) begin
            r.target      = TGT_RAM;
            r.ram_address = {cur_ram_bank, addr[12:0]};
            if (cmd == CMD_WRITE) begin
                r.ram_write      = 1'b1;
                r.ram_write_data = data;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] result %0d: %s got 0x%0h, wanted 0x%0h",
                     $realtime, results_seen, what, got, want);
        end
    endtask

    // offer one beat and hold it until the block takes it; call it from code synchronised to the clock
    task automatic send_access(input logic cmd, input logic [15:0] addr,
                               input logic [DATA_W-1:0] data, input logic typed,
                               input t_result want);
        int unsigned waited;
        t_result     predicted;
        waited = 0;
        req_if.valid       <= 1'b1;
        req_if.command     <= cmd;
        req_if.bus_address <= addr;
        req_if.write_byte  <= data;
        do begin
            @(posedge i_clk);
            waited++;
        end while (!req_if.ready);
        // the beat went in at this edge: predict in acceptance order
        predicted = map_access(cmd, addr, data);
        pending_accesses.push_back(typed ? want : predicted);
        beats_sent++;
        if (waited - 1 > longest_input_stall) begin
            longest_input_stall = waited - 1;
        end
    endtask

    task automatic idle_bus(input int unsigned cycles);
        req_if.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // ram-present may only change with nothing inside the block
    task automatic set_ram_present(input logic value);
        req_if.valid <= 1'b0;
        while (pending_accesses.size() != 0) @(posedge i_clk);
        // two-stage pipe, already empty here: the bus still idles before the register is touched
        repeat (3) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en     <= 1'b0;
        cur_ram_present = value;
        cfg_writes++;
    endtask

    // mostly well-formed traffic: register writes, rom reads, ram window, then noise
    task automatic pick_access(output logic cmd, output logic [15:0] addr,
                               output logic [DATA_W-1:0] data);
        int unsigned kind;
        kind = $urandom_range(0, 99);
        data = DATA_W'($urandom());
        if (kind < 25) begin
            cmd  = CMD_WRITE;
            addr = 16'($urandom_range(0, 16'h7FFF));
            // the enable key is hit more often than chance so ram stays reachable
            if (t_reg_sel'(addr[14:13]) == SEL_RAM_EN && $urandom_range(0, 9) < 7) begin
                data[3:0] = RAM_ENABLE_KEY;
            end
        end else if (kind < 55) begin
            cmd  = CMD_READ;
            addr = 16'($urandom_range(0, 16'h7FFF));
        end else if (kind < 85) begin
            cmd  = 1'($urandom());
            addr = 16'($urandom_range(16'hA000, 16'hBFFF));
        end else begin
            cmd  = 1'($urandom());
            addr = 16'($urandom());
        end
    endtask

    // output side: a stall style picked at random from time to time, plus one long hold-off
    initial begin : receiver
        int unsigned cyc;
        int unsigned style;
        int unsigned hold_left;
        cyc       = 0;
        style     = 0;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 64 == 0) begin
                style = $urandom_range(0, 3);
            end
            if (!long_hold_done && beats_sent >= LONG_HOLD_AT) begin
                hold_left      = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                // the sender keeps offering, so the block backs up into its input
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                case (style)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= ($urandom_range(0, 9) < 7);
                    2:       rsp_if.ready <= (cyc % 3 == 0);
                    default: rsp_if.ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // every output beat is checked against the oldest pending access
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_accesses.size() == 0) begin
                report_mismatch("result with nothing pending, target", 32'(rsp_if.target), 0);
            end else begin
                want = pending_accesses.pop_front();
                if (rsp_if.target !== want.target)
                    report_mismatch("target", 32'(rsp_if.target), 32'(want.target));
                if (rsp_if.rom_address !== want.rom_address)
                    report_mismatch("rom_address", 32'(rsp_if.rom_address), 32'(want.rom_address));
                if (rsp_if.ram_address !== want.ram_address)
                    report_mismatch("ram_address", 32'(rsp_if.ram_address), 32'(want.ram_address));
                if (rsp_if.ram_write !== want.ram_write)
                    report_mismatch("ram_write", 32'(rsp_if.ram_write), 32'(want.ram_write));
                if (rsp_if.ram_write_data !== want.ram_write_data)
                    report_mismatch("ram_write_data", 32'(rsp_if.ram_write_data),
                                    32'(want.ram_write_data));
                case (want.target)
                    TGT_ROM: rom_hits++;
                    TGT_RAM: if (want.ram_write) ram_writes++; else ram_reads++;
                    default: no_hits++;
                endcase
            end
            results_seen++;
        end
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        logic          cmd;
        logic [15:0]   addr;
        logic [7:0]    data;
        int unsigned   burst_left;
        int unsigned   gap;
        logic          phase_present [PHASES];

        phase_present = '{1'b1, 1'b0, 1'b1, 1'b1};
        burst_left    = 0;

        req_if.valid       = 1'b0;
        req_if.command     = CMD_READ;
        req_if.bus_address = '0;
        req_if.write_byte  = '0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_wr_data      = 1'b0;
        i_rst_n            = 1'b0;

        cur_rom_bank    = 7'd1;
        cur_ram_bank    = '0;
        cur_ram_en      = 1'b0;
        cur_ram_mode    = 1'b0;
        cur_ram_present = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows back to back, config rows drain the pipe first
        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
                set_ram_present(DIRECTED_ROWS[i].write_byte[0]);
            end else begin
                send_access(DIRECTED_ROWS[i].command, DIRECTED_ROWS[i].bus_address,
                            DIRECTED_ROWS[i].write_byte, DIRECTED_ROWS[i].typed,
                            DIRECTED_ROWS[i].want);
            end
        end

        // random phases: bursts of beats with random gaps, some bursts gap-free
        for (int p = 0; p < PHASES; p++) begin
            set_ram_present(phase_present[p]);
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap != 0) begin
                        idle_bus(gap);
                    end
                end
                pick_access(cmd, addr, data);
                send_access(cmd, addr, data, 1'b0, NO_HIT);
                burst_left--;
            end
        end
        req_if.valid <= 1'b0;

        // let everything drain, then watch a little longer for stray beats
        while (pending_accesses.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_accesses.size() != 0) begin
            report_mismatch("results never seen, count", pending_accesses.size(), 0);
        end

        $display("%0d accesses checked: %0d rom reads, %0d ram reads, %0d ram writes, %0d no-hit",
                 results_seen, rom_hits, ram_reads, ram_writes, no_hits);
        $display("ram-present written %0d times, longest input stall %0d cycles, %0d mismatches",
                 cfg_writes, longest_input_stall, error_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
